@@ design/assert_macros.svh @@
// assertion helpers shared by the rtl
// each takes a label, the condition terms and a message string
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cidf_pkg.sv @@
package cidf_pkg;

    // field widths
    localparam int ID_W     = 29;
    localparam int KIND_W   = 3;
    localparam int MODE_W   = 2;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;

    // default table depth
    localparam int MAX_KEYS_DEF = 64;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP  = 3'd0,
        KIND_ADD     = 3'd1,
        KIND_REMOVE  = 3'd2,
        KIND_CLEAR   = 3'd3,
        KIND_SETMODE = 3'd4,
        KIND_READ    = 3'd5
    } t_kind;

    // filter modes
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALL      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPECIFIC = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SHIFT,
        ST_RDWAIT,
        ST_DONE
    } t_state;

    // one result word
    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   entry_id;
        logic              entry_dir;
        logic [CNT_W-1:0]  key_count;
        logic [MODE_W-1:0] cur_mode;
    } t_result;

endpackage

@@ design/can_id_observation_filter.sv @@
// CAN id observation filter: an ordered table of (id, direction) keys and a mode.
// Input channel: i_in_valid / o_in_stall with one word per item (kind, frame id,
// direction, new mode, entry index). Output channel: o_out_valid / i_out_stall,
// one result word per input word (ok, entry id/dir, key count, current mode).
// Keys live in one single-port-read memory; lookup, add and remove walk the
// table through that read port, one entry per cycle.
// Clear, set mode, none/all lookups and a full-table add go straight from exec to
// done; read entry waits on the memory read; a lookup, add or failed remove walks
// all N keys held (stopping early when the key is found), and a successful remove
// walks to the end of the table wherever the key sits, since the compaction moves
// the rest of it. A new word is taken once the previous result sits in the output register.
// Reset empties the table and sets the mode to none; the memory needs no
// clearing. When the receiver stalls, the result holds in the output register,
// the next item is still accepted and worked on, and its result waits inside
// until the output register frees up.
`include "assert_macros.svh"

module can_id_observation_filter #(
    parameter int MAX_KEYS = cidf_pkg::MAX_KEYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [cidf_pkg::KIND_W-1:0] i_kind,
    input  logic [cidf_pkg::ID_W-1:0]   i_frame_id,
    input  logic                        i_path_dir,
    input  logic [cidf_pkg::MODE_W-1:0] i_new_mode,
    input  logic [cidf_pkg::IDX_W-1:0]  i_entry_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_ok,
    output logic [cidf_pkg::ID_W-1:0]   o_entry_id,
    output logic                        o_entry_dir,
    output logic [cidf_pkg::CNT_W-1:0]  o_key_count,
    output logic [cidf_pkg::MODE_W-1:0] o_cur_mode
);

    cidf_pkg::t_result res;
    logic              res_valid;
    logic              res_rdy;

    logic              r_out_valid, n_out_valid;
    cidf_pkg::t_result r_out;

    cidf_ctrl #(
        .MAX_KEYS (MAX_KEYS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_frame_id    (i_frame_id),
        .i_path_dir    (i_path_dir),
        .i_new_mode    (i_new_mode),
        .i_entry_index (i_entry_index),
        .o_res_valid   (res_valid),
        .i_res_rdy     (res_rdy),
        .o_res         (res)
    );

    // output register takes a word when empty or being drained
    assign res_rdy = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_rdy) begin
            n_out_valid = res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_rdy && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_out.ok;
    assign o_entry_id  = r_out.entry_id;
    assign o_entry_dir = r_out.entry_dir;
    assign o_key_count = r_out.key_count;
    assign o_cur_mode  = r_out.cur_mode;

    // checks
    `ASSERT_SAME(a_count_range, o_out_valid, (MAX_KEYS > 127) || (32'(o_key_count) <= MAX_KEYS), "key count above table depth")
    `ASSERT_SAME(a_mode_code, o_out_valid, o_cur_mode <= cidf_pkg::MODE_SPECIFIC, "bad mode code")
    `ASSERT_SAME(a_fail_zero, o_out_valid && !o_ok, (o_entry_id == '0) && !o_entry_dir, "entry fields set on failure")
    `ASSERT_NEXT(a_res_hold, res_valid && !res_rdy, res_valid && $stable(res), "pending result lost")

endmodule

@@ design/cidf_ram.sv @@
module cidf_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // one registered read port, holds when idle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/cidf_ctrl.sv @@
module cidf_ctrl #(
    parameter int MAX_KEYS = cidf_pkg::MAX_KEYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [cidf_pkg::KIND_W-1:0] i_kind,
    input  logic [cidf_pkg::ID_W-1:0]   i_frame_id,
    input  logic                        i_path_dir,
    input  logic [cidf_pkg::MODE_W-1:0] i_new_mode,
    input  logic [cidf_pkg::IDX_W-1:0]  i_entry_index,
    output logic                        o_res_valid,
    input  logic                        i_res_rdy,
    output cidf_pkg::t_result           o_res
);

    localparam int AW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW   = $clog2(MAX_KEYS + 1);
    localparam int DW   = cidf_pkg::ID_W + 1;
    localparam int CMPW = (CW > cidf_pkg::IDX_W) ? CW : cidf_pkg::IDX_W;

    cidf_pkg::t_state r_state, n_state;

    // captured word
    cidf_pkg::t_kind             r_kind;
    logic [cidf_pkg::ID_W-1:0]   r_id;
    logic                        r_dir;
    logic [cidf_pkg::MODE_W-1:0] r_mode_in;
    logic [cidf_pkg::IDX_W-1:0]  r_idx;

    // table state outside the memory
    logic [CW-1:0]               r_count, n_count;
    logic [cidf_pkg::MODE_W-1:0] r_mode, n_mode;

    // walk pointers
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_issued, n_issued;
    logic [AW-1:0] r_cmp_addr, n_cmp_addr;

    // result payload
    logic                      r_res_ok, n_res_ok;
    logic [cidf_pkg::ID_W-1:0] r_res_id, n_res_id;
    logic                      r_res_dir, n_res_dir;

    // memory port
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] wr_data, rd_data;

    logic accept;
    logic key_hit;
    logic walk_end;
    logic idx_ok;
    logic tbl_full;

    cidf_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall = (r_state != cidf_pkg::ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // status terms
    assign key_hit  = r_issued && (rd_data == {r_id, r_dir});
    assign walk_end = (r_ptr >= r_count);
    assign idx_ok   = (CMPW'(r_idx) < CMPW'(r_count));
    assign tbl_full = (r_count >= CW'(MAX_KEYS));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cidf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = cidf_pkg::ST_EXEC;
                end
            end
            cidf_pkg::ST_EXEC: begin
                unique case (r_kind)
                    cidf_pkg::KIND_LOOKUP: begin
                        n_state = (r_mode == cidf_pkg::MODE_SPECIFIC) ?
                                  cidf_pkg::ST_SCAN : cidf_pkg::ST_DONE;
                    end
                    cidf_pkg::KIND_ADD: begin
                        n_state = tbl_full ? cidf_pkg::ST_DONE : cidf_pkg::ST_SCAN;
                    end
                    cidf_pkg::KIND_REMOVE: begin
                        n_state = cidf_pkg::ST_SCAN;
                    end
                    cidf_pkg::KIND_READ: begin
                        n_state = idx_ok ? cidf_pkg::ST_RDWAIT : cidf_pkg::ST_DONE;
                    end
                    default: begin
                        n_state = cidf_pkg::ST_DONE;
                    end
                endcase
            end
            cidf_pkg::ST_SCAN: begin
                priority if (key_hit) begin
                    n_state = (r_kind == cidf_pkg::KIND_REMOVE) ?
                              cidf_pkg::ST_SHIFT : cidf_pkg::ST_DONE;
                end else if (walk_end) begin
                    n_state = cidf_pkg::ST_DONE;
                end else begin
                    n_state = cidf_pkg::ST_SCAN;
                end
            end
            cidf_pkg::ST_SHIFT: begin
                if (walk_end) begin
                    n_state = cidf_pkg::ST_DONE;
                end
            end
            cidf_pkg::ST_RDWAIT: begin
                n_state = cidf_pkg::ST_DONE;
            end
            cidf_pkg::ST_DONE: begin
                if (i_res_rdy) begin
                    n_state = cidf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cidf_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count    = r_count;
        n_mode     = r_mode;
        n_ptr      = r_ptr;
        n_issued   = r_issued;
        n_cmp_addr = r_cmp_addr;
        n_res_ok   = r_res_ok;
        n_res_id   = r_res_id;
        n_res_dir  = r_res_dir;
        rd_en      = 1'b0;
        rd_addr    = r_ptr[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_cmp_addr;
        wr_data    = rd_data;

        unique case (r_state)
            cidf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_ptr    = '0;
                    n_issued = 1'b0;
                end
            end
            cidf_pkg::ST_EXEC: begin
                n_res_ok  = 1'b1;
                n_res_id  = '0;
                n_res_dir = 1'b0;
                unique case (r_kind)
                    cidf_pkg::KIND_LOOKUP: begin
                        if (r_mode != cidf_pkg::MODE_SPECIFIC) begin
                            n_res_ok = (r_mode == cidf_pkg::MODE_ALL);
                        end
                    end
                    cidf_pkg::KIND_ADD: begin
                        if (tbl_full) begin
                            n_res_ok = 1'b0;
                        end
                    end
                    cidf_pkg::KIND_CLEAR: begin
                        n_count = '0;
                    end
                    cidf_pkg::KIND_SETMODE: begin
                        if (r_mode_in <= cidf_pkg::MODE_SPECIFIC) begin
                            n_mode = r_mode_in;
                        end
                    end
                    cidf_pkg::KIND_READ: begin
                        if (idx_ok) begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(r_idx);
                        end else begin
                            n_res_ok = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            cidf_pkg::ST_SCAN: begin
                // keep one read in flight, compare the previous one
                n_issued = 1'b0;
                if (!key_hit && !walk_end) begin
                    rd_en      = 1'b1;
                    n_ptr      = r_ptr + CW'(1);
                    n_issued   = 1'b1;
                    n_cmp_addr = r_ptr[AW-1:0];
                end
                priority if (key_hit) begin
                    // found: lookup hits, add only sets mode, remove starts shifting
                    if (r_kind == cidf_pkg::KIND_ADD) begin
                        n_mode = cidf_pkg::MODE_SPECIFIC;
                    end
                    n_ptr = CW'(r_cmp_addr) + CW'(1);
                end else if (walk_end) begin
                    // not found
                    if (r_kind == cidf_pkg::KIND_ADD) begin
                        wr_en   = 1'b1;
                        wr_addr = r_count[AW-1:0];
                        wr_data = {r_id, r_dir};
                        n_count = r_count + CW'(1);
                        n_mode  = cidf_pkg::MODE_SPECIFIC;
                    end else begin
                        n_res_ok = 1'b0;
                    end
                end else begin
                end
            end
            cidf_pkg::ST_SHIFT: begin
                // move each later entry down by one
                if (r_issued) begin
                    wr_en   = 1'b1;
                    wr_addr = r_cmp_addr - AW'(1);
                    wr_data = rd_data;
                end
                n_issued = 1'b0;
                if (!walk_end) begin
                    rd_en      = 1'b1;
                    n_ptr      = r_ptr + CW'(1);
                    n_issued   = 1'b1;
                    n_cmp_addr = r_ptr[AW-1:0];
                end else begin
                    n_count = r_count - CW'(1);
                    n_mode  = (r_count > CW'(1)) ? cidf_pkg::MODE_SPECIFIC :
                                                   cidf_pkg::MODE_NONE;
                end
            end
            cidf_pkg::ST_RDWAIT: begin
                n_res_id  = rd_data[DW-1:1];
                n_res_dir = rd_data[0];
            end
            cidf_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cidf_pkg::ST_IDLE;
            r_count  <= '0;
            r_mode   <= cidf_pkg::MODE_NONE;
            r_issued <= 1'b0;
            r_ptr    <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_mode   <= n_mode;
            r_issued <= n_issued;
            r_ptr    <= n_ptr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= cidf_pkg::t_kind'(i_kind);
            r_id      <= i_frame_id;
            r_dir     <= i_path_dir;
            r_mode_in <= i_new_mode;
            r_idx     <= i_entry_index;
        end
        r_cmp_addr <= n_cmp_addr;
        r_res_ok   <= n_res_ok;
        r_res_id   <= n_res_id;
        r_res_dir  <= n_res_dir;
    end

    // result word
    assign o_res_valid      = (r_state == cidf_pkg::ST_DONE);
    assign o_res.ok         = r_res_ok;
    assign o_res.entry_id   = r_res_id;
    assign o_res.entry_dir  = r_res_dir;
    assign o_res.key_count  = cidf_pkg::CNT_W'(r_count);
    assign o_res.cur_mode   = r_mode;

endmodule

@@ dv/cidf_shadow_pkg.sv @@
package cidf_shadow_pkg;
    import cidf_pkg::*;

    localparam int TABLE_DEPTH = MAX_KEYS_DEF;

    // codes the block decodes as no-ops
    localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
    localparam logic [MODE_W-1:0] MODE_BAD    = 2'd3;

    // shadow copy of the key table, plus the answers the block still owes
    class key_table_shadow;
        logic [ID_W-1:0]   held_ids [TABLE_DEPTH];
        logic              held_dirs[TABLE_DEPTH];
        int                held;
        logic [MODE_W-1:0] mode;
        t_result           answers_due[$];

        int errors;
        int checked;
        int peak;
        int hits;
        int refused;
        int removed;
        int kind_tally[8];

        function new();
            held    = 0;
            mode    = MODE_NONE;
            errors  = 0;
            checked = 0;
            peak    = 0;
            hits    = 0;
            refused = 0;
            removed = 0;
            foreach (kind_tally[k]) kind_tally[k] = 0;
        endfunction

        // position of a key, or held when it is absent
        function int locate(logic [ID_W-1:0] id, logic dir);
            for (int i = 0; i < held; i++) begin
                if (held_ids[i] == id && held_dirs[i] == dir) return i;
            end
            return held;
        endfunction

        // a random key currently in the table
        function bit pick_held(output logic [ID_W-1:0] id, output logic dir);
            int slot;
            if (held == 0) return 1'b0;
            slot = $urandom_range(0, held - 1);
            id   = held_ids[slot];
            dir  = held_dirs[slot];
            return 1'b1;
        endfunction

        // apply one accepted word and queue the answer it must produce
        function void note_word(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id, logic dir,
                                logic [MODE_W-1:0] new_mode, logic [IDX_W-1:0] idx);
            t_result r;
            int      pos;
            r    = '0;
            r.ok = 1'b1;
            kind_tally[kind]++;
            case (kind)
                KIND_LOOKUP: begin
                    if (mode == MODE_ALL) r.ok = 1'b1;
                    else if (mode == MODE_SPECIFIC) r.ok = (locate(id, dir) < held);
                    else r.ok = 1'b0;
                    if (r.ok) hits++;
                end
                KIND_ADD: begin
                    // a full table refuses even a key it already holds
                    if (held >= TABLE_DEPTH) begin
                        r.ok = 1'b0;
                        refused++;
                    end else begin
                        if (locate(id, dir) == held) begin
                            held_ids[held]  = id;
                            held_dirs[held] = dir;
                            held++;
                        end
                        mode = MODE_SPECIFIC;
                    end
                end
                KIND_REMOVE: begin
                    pos = locate(id, dir);
                    if (pos == held) begin
                        r.ok = 1'b0;
                    end else begin
                        // close the gap, keeping order
                        for (int i = pos; i < held - 1; i++) begin
                            held_ids[i]  = held_ids[i + 1];
                            held_dirs[i] = held_dirs[i + 1];
                        end
                        held--;
                        mode = (held > 0) ? MODE_SPECIFIC : MODE_NONE;
                        removed++;
                    end
                end
                KIND_CLEAR: held = 0;
                KIND_SETMODE: if (new_mode != MODE_BAD) mode = new_mode;
                KIND_READ: begin
                    if (idx < held) begin
                        r.entry_id  = held_ids[idx];
                        r.entry_dir = held_dirs[idx];
                    end else begin
                        r.ok = 1'b0;
                    end
                end
                default: ;
            endcase
            if (held > peak) peak = held;
            r.key_count = CNT_W'(held);
            r.cur_mode  = mode;
            answers_due.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("mismatch on answer %0d: %s", checked, what);
        endtask

        // compare one delivered result word with the oldest answer due
        task compare_answer(t_result got);
            t_result want;
            if (answers_due.size() == 0) begin
                report($sformatf("result word with no answer due (ok %0b count %0d)",
                                 got.ok, got.key_count));
                return;
            end
            want = answers_due.pop_front();
            checked++;
            if (got.ok !== want.ok)
                report($sformatf("ok %0b, want %0b", got.ok, want.ok));
            if (got.entry_id !== want.entry_id)
                report($sformatf("entry_id %h, want %h", got.entry_id, want.entry_id));
            if (got.entry_dir !== want.entry_dir)
                report($sformatf("entry_dir %0b, want %0b", got.entry_dir, want.entry_dir));
            if (got.key_count !== want.key_count)
                report($sformatf("key_count %0d, want %0d", got.key_count, want.key_count));
            if (got.cur_mode !== want.cur_mode)
                report($sformatf("cur_mode %0d, want %0d", got.cur_mode, want.cur_mode));
        endtask
    endclass

endpackage

@@ dv/can_id_observation_filter_test.sv @@
module can_id_observation_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cidf_pkg::*;
    import cidf_shadow_pkg::*;

    localparam int WORD_TARGET = 1950;
    localparam int QUIET_TAIL  = 150;
    localparam int LONG_HOLD   = 400;
    // longest walk plus compaction on a full table, with margin
    localparam int SETTLE      = 200;
    localparam int CYCLE_LIMIT = 1_500_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [KIND_W-1:0] i_kind;
    logic [ID_W-1:0]   i_frame_id;
    logic              i_path_dir;
    logic [MODE_W-1:0] i_new_mode;
    logic [IDX_W-1:0]  i_entry_index;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_ok;
    logic [ID_W-1:0]   o_entry_id;
    logic              o_entry_dir;
    logic [CNT_W-1:0]  o_key_count;
    logic [MODE_W-1:0] o_cur_mode;

    key_table_shadow shadow = new();

    int words_sent = 0;
    int cycles     = 0;
    int tx_calm    = 0;
    bit quiet      = 1'b0;
    bit hold_req   = 1'b0;

    can_id_observation_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_frame_id    (i_frame_id),
        .i_path_dir    (i_path_dir),
        .i_new_mode    (i_new_mode),
        .i_entry_index (i_entry_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_entry_id    (o_entry_id),
        .o_entry_dir   (o_entry_dir),
        .o_key_count   (o_key_count),
        .o_cur_mode    (o_cur_mode)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers still due", cycles,
                     shadow.answers_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // offer one word and hold it until the block takes it
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                             input logic dir, input logic [MODE_W-1:0] nm,
                             input logic [IDX_W-1:0] idx);
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_frame_id    <= id;
        i_path_dir    <= dir;
        i_new_mode    <= nm;
        i_entry_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        shadow.note_word(kind, id, dir, nm, idx);
        words_sent++;
    endtask

    task automatic tx_gap(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // random sender bursts, with calm stretches between them
    task automatic maybe_gap();
        if (quiet) return;
        if (tx_calm > 0) begin
            tx_calm--;
        end else if ($urandom_range(0, 24) == 0) begin
            tx_calm = $urandom_range(15, 60);
        end else if ($urandom_range(0, 5) == 0) begin
            tx_gap($urandom_range(1, 10));
        end
    endtask

    // stop offering until every answer has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (shadow.answers_due.size() != 0);
    endtask

    function automatic logic [ID_W-1:0] fresh_id();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return ID_W'($urandom_range(0, 15));
            default: return ID_W'($urandom);
        endcase
    endfunction

    // mostly keys that are held, so lookups and removes hit
    function automatic void pick_key(output logic [ID_W-1:0] id, output logic dir);
        if ($urandom_range(0, 2) != 0 && shadow.pick_held(id, dir)) return;
        id  = fresh_id();
        dir = 1'($urandom_range(0, 1));
    endfunction

    // one word of a given kind with random content
    task automatic send_random(input logic [KIND_W-1:0] kind);
        logic [ID_W-1:0]   id;
        logic              dir;
        logic [MODE_W-1:0] nm;
        logic [IDX_W-1:0]  idx;
        pick_key(id, dir);
        nm  = ($urandom_range(0, 5) == 0) ? MODE_BAD : MODE_W'($urandom_range(0, 2));
        idx = IDX_W'($urandom_range(0, 63));
        if (kind == KIND_READ && shadow.held > 0 && $urandom_range(0, 2) != 0)
            idx = IDX_W'($urandom_range(0, shadow.held - 1));
        send_word(kind, id, dir, nm, idx);
        maybe_gap();
    endtask

    // mixed traffic
    task automatic run_mixed(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 35) send_random(KIND_LOOKUP);
            else if (r < 55) send_random(KIND_ADD);
            else if (r < 70) send_random(KIND_REMOVE);
            else if (r < 82) send_random(KIND_READ);
            else if (r < 91) send_random(KIND_SETMODE);
            else if (r < 94) send_random(KIND_CLEAR);
            else send_random($urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7);
        end
    endtask

    // fill the table to the top, then poke at it while full
    task automatic run_fill();
        logic [ID_W-1:0] id;
        logic            dir;
        while (shadow.held < TABLE_DEPTH) begin
            if ($urandom_range(0, 4) == 0) begin
                send_random(KIND_LOOKUP);
            end else begin
                id  = ID_W'($urandom);
                dir = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 7) == 0 && shadow.held > 0)
                    void'(shadow.pick_held(id, dir));
                send_word(KIND_ADD, id, dir, MODE_W'($urandom_range(0, 3)),
                          IDX_W'($urandom));
                maybe_gap();
            end
        end
        repeat ($urandom_range(3, 8)) begin
            case ($urandom_range(0, 3))
                0: send_random(KIND_ADD);
                1: send_random(KIND_LOOKUP);
                2: send_random(KIND_READ);
                default: begin
                    void'(shadow.pick_held(id, dir));
                    send_word(KIND_ADD, id, dir, MODE_SPECIFIC, '1);
                end
            endcase
        end
    endtask

    // remove keys until the table is empty
    task automatic run_drain();
        logic [ID_W-1:0] id;
        logic            dir;
        while (shadow.held > 0) begin
            case ($urandom_range(0, 7))
                0: send_random(KIND_READ);
                1: send_random(KIND_LOOKUP);
                2: begin
                    id = ID_W'($urandom);
                    send_word(KIND_REMOVE, id, 1'($urandom_range(0, 1)), '0, '0);
                end
                default: begin
                    void'(shadow.pick_held(id, dir));
                    send_word(KIND_REMOVE, id, dir, MODE_W'($urandom_range(0, 3)),
                              IDX_W'($urandom));
                    maybe_gap();
                end
            endcase
        end
    endtask

    // edge cases of every operation
    task automatic run_directed();
        send_word(KIND_LOOKUP, '1, 1'b1, '0, '0);
        send_word(KIND_READ, '0, 1'b0, '0, '0);
        send_word(KIND_REMOVE, 29'd5, 1'b0, '0, '0);
        send_word(KIND_SETMODE, '0, 1'b0, MODE_ALL, '0);
        send_word(KIND_LOOKUP, 29'h0ABCDEF1, 1'b0, '0, '0);
        send_word(KIND_SETMODE, '0, 1'b0, MODE_BAD, '0);
        send_word(KIND_ADD, '1, 1'b1, '0, '0);
        send_word(KIND_ADD, '0, 1'b0, '0, '0);
        send_word(KIND_ADD, '1, 1'b1, '0, '0);
        send_word(KIND_ADD, 29'h0AAAAAAA, 1'b1, '0, '0);
        send_word(KIND_LOOKUP, '1, 1'b1, '0, '0);
        send_word(KIND_LOOKUP, '1, 1'b0, '0, '0);
        send_word(KIND_READ, '0, 1'b0, '0, 6'd0);
        send_word(KIND_READ, '0, 1'b0, '0, 6'd2);
        send_word(KIND_READ, '0, 1'b0, '0, 6'd3);
        send_word(KIND_READ, '0, 1'b0, '0, '1);
        send_word(KIND_REMOVE, '0, 1'b0, '0, '0);
        send_word(KIND_READ, '0, 1'b0, '0, 6'd1);
        send_word(KIND_SPARE6, '1, 1'b1, '1, '1);
        send_word(KIND_SPARE7, '0, 1'b0, '0, '0);
        send_word(KIND_SETMODE, '0, 1'b0, MODE_NONE, '0);
        send_word(KIND_LOOKUP, '1, 1'b1, '0, '0);
        send_word(KIND_CLEAR, '0, 1'b0, '0, '0);
        send_word(KIND_ADD, 29'd5, 1'b0, '0, '0);
        send_word(KIND_REMOVE, 29'd5, 1'b0, '0, '0);
    endtask

    // receiver: check each delivered word, stall in bursts or on a long hold
    initial begin
        int      stall_left;
        int      hold_left;
        int      calm_left;
        t_result got;
        stall_left = 0;
        hold_left  = 0;
        calm_left  = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.ok        = o_ok;
                got.entry_id  = o_entry_id;
                got.entry_dir = o_entry_dir;
                got.key_count = o_key_count;
                got.cur_mode  = o_cur_mode;
                shadow.compare_answer(got);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            // no stalls at all in the closing stretch
            if (quiet) begin
                hold_left  = 0;
                stall_left = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (quiet || calm_left > 0) begin
                if (calm_left > 0) calm_left--;
                i_out_stall <= 1'b0;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2: begin
                        stall_left = $urandom_range(0, 9);
                        i_out_stall <= 1'b1;
                    end
                    3: begin
                        calm_left = $urandom_range(20, 100);
                        i_out_stall <= 1'b0;
                    end
                    default: i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    // sender and run control
    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_kind        <= KIND_LOOKUP;
        i_frame_id    <= '0;
        i_path_dir    <= 1'b0;
        i_new_mode    <= MODE_NONE;
        i_entry_index <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        wait_drained();

        // long receiver hold while words keep coming
        hold_req = 1'b1;
        run_mixed(40);

        while (words_sent < WORD_TARGET) begin
            quiet = (words_sent >= WORD_TARGET - QUIET_TAIL);
            case ($urandom_range(0, 7))
                0, 1: run_fill();
                2, 3: run_drain();
                default: run_mixed($urandom_range(10, 60));
            endcase
            if (!quiet && $urandom_range(0, 5) == 0) wait_drained();
            if (!quiet && $urandom_range(0, 14) == 0) hold_req = 1'b1;
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d words: %0d lookups (%0d hits), %0d adds (%0d refused when full)",
                 words_sent, shadow.kind_tally[KIND_LOOKUP], shadow.hits,
                 shadow.kind_tally[KIND_ADD], shadow.refused);
        $display("%0d removes (%0d found), %0d reads, %0d clears, %0d mode writes, "
                 , shadow.kind_tally[KIND_REMOVE], shadow.removed,
                 shadow.kind_tally[KIND_READ], shadow.kind_tally[KIND_CLEAR],
                 shadow.kind_tally[KIND_SETMODE],
                 "%0d spare codes, peak %0d keys, %0d results checked",
                 shadow.kind_tally[KIND_SPARE6] + shadow.kind_tally[KIND_SPARE7],
                 shadow.peak, shadow.checked);
        if (shadow.errors == 0 && shadow.answers_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/cidf_pkg.sv
design/cidf_ram.sv
design/cidf_ctrl.sv
design/can_id_observation_filter.sv
dv/cidf_shadow_pkg.sv
dv/can_id_observation_filter_test.sv
